[hdl/pfs_pkg.sv]
package pfs_pkg;

  localparam int MAX_DEPTH_DEF     = 64;
  localparam int DEFAULT_DEPTH_DEF = 8;
  localparam int MAX_DRAIN_DEF     = 64;

  localparam int STAMP_W  = 64;
  localparam int PERIOD_W = 20;
  localparam int DEPTH_W  = 7;
  localparam int CNT_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = PERIOD_W;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 1'd1;

  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_OFFER   = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // Request to and answer from the shared 64-bit adder/subtractor.
  typedef struct packed {
    logic [STAMP_W-1:0] a;
    logic [STAMP_W-1:0] b;
    logic               sub;
  } au_req_t;

  typedef struct packed {
    logic [STAMP_W-1:0] res;
    logic               borrow;
  } au_rsp_t;

  typedef struct packed {
    logic               status;
    logic [DEPTH_W-1:0] starved_frames;
    logic               ready_res;
    logic [DEPTH_W-1:0] queued_count;
    logic [CNT_W-1:0]   accepted_count;
    logic [CNT_W-1:0]   refused_count;
    logic [CNT_W-1:0]   drained_count;
    logic [CNT_W-1:0]   underrun_count;
    logic [CNT_W-1:0]   resync_count;
    logic [CNT_W-1:0]   skew_count;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

[hdl/pfs_if.sv]
interface pfs_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] now_us;

  modport source (output valid, output req_type, output now_us, input ready);
  modport sink (input valid, input req_type, input now_us, output ready);
endinterface

interface pfs_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [6:0]  starved_frames;
  logic        ready_res;
  logic [6:0]  queued_count;
  logic [31:0] accepted_count;
  logic [31:0] refused_count;
  logic [31:0] drained_count;
  logic [31:0] underrun_count;
  logic [31:0] resync_count;
  logic [31:0] skew_count;

  modport source (
    output valid, output status, output starved_frames, output ready_res,
    output queued_count, output accepted_count, output refused_count,
    output drained_count, output underrun_count, output resync_count,
    output skew_count, input ready
  );
  modport sink (
    input valid, input status, input starved_frames, input ready_res,
    input queued_count, input accepted_count, input refused_count,
    input drained_count, input underrun_count, input resync_count,
    input skew_count, output ready
  );
endinterface

[hdl/paced_frame_sink.sv]
// Channel   Dir  Beat contents
// --------  ---  -----------------------------------------------------------
// in_bus    in   req_type (advance or offer), now_us timestamp
// out_bus   out  status, starved_frames, ready_res, queued_count, six totals
// cfg_*     in   write-only register port: frame period (0), queue depth (1)
//
// With the output register free, an offer passes ST_OFFER and ST_DONE before it
// is registered, an unpaced advance only ST_DONE. A paced advance runs ST_SKEW,
// then ST_ANCHOR or ST_DUE, ST_DIV, ST_BACK and ST_FWD: the count of due frames
// is found by repeated subtraction of the period on one shared 64-bit adder,
// one step per cycle, capped at MAX_DRAIN plus one steps. Reset is synchronous
// and clears the schedule, the queue fill, every total and both registers. The
// input is taken only while the sequencer is idle; one finished result can sit
// in the output register while the next beat is accepted and worked on.
module paced_frame_sink #(
  parameter int MAX_DEPTH     = pfs_pkg::MAX_DEPTH_DEF,
  parameter int DEFAULT_DEPTH = pfs_pkg::DEFAULT_DEPTH_DEF,
  parameter int MAX_DRAIN     = pfs_pkg::MAX_DRAIN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pfs_in_if.sink                          in_bus,
  pfs_out_if.source                       out_bus,
  input  logic                            cfg_we,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pfs_pkg::*;

  logic [PERIOD_W-1:0] period_r;
  logic [DEPTH_W-1:0]  depth_r;
  au_req_t             au_req;
  au_rsp_t             au_rsp;
  logic                seq_idle;
  logic                res_valid;
  logic                res_ready;
  result_t             res;
  result_t             out_r;
  logic                out_valid_r;
  logic                start;

  // Configuration registers. The user must write them only while the block is
  // idle; the block does not enforce this. The sequencer reads them directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      depth_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD: period_r <= cfg_wdata;
        REG_DEPTH:  depth_r  <= cfg_wdata[DEPTH_W-1:0];
        default:    period_r <= period_r;
      endcase
    end
  end

  assign in_bus.ready = seq_idle;
  assign start        = in_bus.valid && seq_idle;

  pfs_addsub u_addsub (
    .req (au_req),
    .rsp (au_rsp)
  );

  pfs_seq #(
    .MAX_DEPTH     (MAX_DEPTH),
    .DEFAULT_DEPTH (DEFAULT_DEPTH),
    .MAX_DRAIN     (MAX_DRAIN)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .start_offer (in_bus.req_type),
    .start_now   (in_bus.now_us),
    .idle        (seq_idle),
    .period      (period_r),
    .depth       (depth_r),
    .au_req      (au_req),
    .au_rsp      (au_rsp),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // One-deep output register: the sequencer hands a result over whenever the
  // register is empty or being emptied in the same cycle.
  assign res_ready = !out_valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.status         = out_r.status;
  assign out_bus.starved_frames = out_r.starved_frames;
  assign out_bus.ready_res      = out_r.ready_res;
  assign out_bus.queued_count   = out_r.queued_count;
  assign out_bus.accepted_count = out_r.accepted_count;
  assign out_bus.refused_count  = out_r.refused_count;
  assign out_bus.drained_count  = out_r.drained_count;
  assign out_bus.underrun_count = out_r.underrun_count;
  assign out_bus.resync_count   = out_r.resync_count;
  assign out_bus.skew_count     = out_r.skew_count;

endmodule

[hdl/pfs_addsub.sv]
module pfs_addsub (
  input  pfs_pkg::au_req_t req,
  output pfs_pkg::au_rsp_t rsp
);
  import pfs_pkg::*;

  logic [STAMP_W:0] sum;

  // Subtraction is a + ~b + 1; a missing carry out means a < b.
  assign sum = {1'b0, req.a} + {1'b0, req.b ^ {STAMP_W{req.sub}}} + (STAMP_W+1)'(req.sub);
  assign rsp.res    = sum[STAMP_W-1:0];
  assign rsp.borrow = req.sub & ~sum[STAMP_W];

endmodule

[hdl/pfs_seq.sv]
module pfs_seq #(
  parameter int MAX_DEPTH     = pfs_pkg::MAX_DEPTH_DEF,
  parameter int DEFAULT_DEPTH = pfs_pkg::DEFAULT_DEPTH_DEF,
  parameter int MAX_DRAIN     = pfs_pkg::MAX_DRAIN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          start_offer,
  input  logic [pfs_pkg::STAMP_W-1:0]   start_now,
  output logic                          idle,
  input  logic [pfs_pkg::PERIOD_W-1:0]  period,
  input  logic [pfs_pkg::DEPTH_W-1:0]   depth,
  output pfs_pkg::au_req_t              au_req,
  input  pfs_pkg::au_rsp_t              au_rsp,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pfs_pkg::result_t              res
);
  import pfs_pkg::*;

  localparam int CAP_MAX = (MAX_DEPTH > DEFAULT_DEPTH) ? MAX_DEPTH : DEFAULT_DEPTH;
  localparam int QW = $clog2(CAP_MAX + 1);
  localparam int RW = $clog2(MAX_DRAIN + 2);
  localparam int XW = (QW > RW) ? QW : RW;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_OFFER  = 9'b000000010,
    ST_SKEW   = 9'b000000100,
    ST_ANCHOR = 9'b000001000,
    ST_DUE    = 9'b000010000,
    ST_DIV    = 9'b000100000,
    ST_BACK   = 9'b001000000,
    ST_FWD    = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic               offer_r;
  logic [STAMP_W-1:0] now_r;
  logic               running_r, running_nxt;
  logic [STAMP_W-1:0] last_stamp_r, last_stamp_nxt;
  logic [STAMP_W-1:0] next_due_r, next_due_nxt;
  logic [STAMP_W-1:0] rem_r, rem_nxt;
  logic [RW-1:0]      reached_r, reached_nxt;
  logic               resync_r, resync_nxt;
  logic               play_r, play_nxt;
  logic [QW-1:0]      queued_r, queued_nxt;
  logic               status_r, status_nxt;
  logic [DEPTH_W-1:0] starved_r, starved_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   ref_r, ref_nxt;
  logic [CNT_W-1:0]   drn_r, drn_nxt;
  logic [CNT_W-1:0]   und_r, und_nxt;
  logic [CNT_W-1:0]   rsy_r, rsy_nxt;
  logic [CNT_W-1:0]   skw_r, skw_nxt;

  logic [STAMP_W-1:0] per64;
  logic               paced;
  logic [QW-1:0]      cap;
  logic [XW-1:0]      due, played, starved, qx;

  assign per64 = STAMP_W'(period);
  assign paced = (period != '0);

  always_comb begin
    if (depth == '0) begin
      cap = QW'(DEFAULT_DEPTH);
    end else if (32'(depth) > 32'(MAX_DEPTH)) begin
      cap = QW'(MAX_DEPTH);
    end else begin
      cap = QW'(depth);
    end
  end

  // Frames played out at the end of a drain.
  assign due     = resync_r ? XW'(MAX_DRAIN) : XW'(reached_r);
  assign qx      = XW'(queued_r);
  assign played  = (due < qx) ? due : qx;
  assign starved = due - played;

  // Operand selection for the shared adder.
  always_comb begin
    au_req.a   = now_r;
    au_req.b   = last_stamp_r;
    au_req.sub = 1'b1;
    case (state_r)
      ST_ANCHOR: begin
        au_req.b   = per64;
        au_req.sub = 1'b0;
      end
      ST_DUE: begin
        au_req.b = next_due_r;
      end
      ST_DIV: begin
        au_req.a = rem_r;
        au_req.b = per64;
      end
      ST_BACK: begin
        au_req.b = rem_r;
      end
      ST_FWD: begin
        au_req.a   = resync_r ? now_r : rem_r;
        au_req.b   = per64;
        au_req.sub = 1'b0;
      end
      default: begin
        au_req.b = last_stamp_r;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    running_nxt    = running_r;
    last_stamp_nxt = last_stamp_r;
    next_due_nxt   = next_due_r;
    rem_nxt        = rem_r;
    reached_nxt    = reached_r;
    resync_nxt     = resync_r;
    play_nxt       = play_r;
    queued_nxt     = queued_r;
    status_nxt     = status_r;
    starved_nxt    = starved_r;
    acc_nxt        = acc_r;
    ref_nxt        = ref_r;
    drn_nxt        = drn_r;
    und_nxt        = und_r;
    rsy_nxt        = rsy_r;
    skw_nxt        = skw_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          status_nxt  = STATUS_OK;
          starved_nxt = '0;
          play_nxt    = 1'b0;
          if (start_offer == REQ_OFFER) begin
            state_nxt = ST_OFFER;
          end else if (!paced) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SKEW;
          end
        end
      end
      ST_OFFER: begin
        if (!paced) begin
          acc_nxt = sat_add(acc_r, 32'd1);
        end else if (queued_r >= cap) begin
          ref_nxt    = sat_add(ref_r, 32'd1);
          status_nxt = STATUS_REFUSED;
        end else begin
          queued_nxt = queued_r + QW'(1);
          acc_nxt    = sat_add(acc_r, 32'd1);
        end
        state_nxt = ST_DONE;
      end
      ST_SKEW: begin
        if (running_r && au_rsp.borrow) begin
          skw_nxt   = sat_add(skw_r, 32'd1);
          state_nxt = ST_DONE;
        end else begin
          last_stamp_nxt = now_r;
          state_nxt      = running_r ? ST_DUE : ST_ANCHOR;
        end
      end
      ST_ANCHOR: begin
        running_nxt  = 1'b1;
        next_due_nxt = au_rsp.res;
        state_nxt    = ST_DONE;
      end
      ST_DUE: begin
        if (au_rsp.borrow) begin
          state_nxt = ST_DONE;
        end else begin
          rem_nxt     = au_rsp.res;
          reached_nxt = RW'(1);
          resync_nxt  = 1'b0;
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (reached_r == RW'(MAX_DRAIN + 1)) begin
          resync_nxt = 1'b1;
          state_nxt  = ST_FWD;
        end else if (au_rsp.borrow) begin
          state_nxt = ST_BACK;
        end else begin
          rem_nxt     = au_rsp.res;
          reached_nxt = reached_r + RW'(1);
        end
      end
      ST_BACK: begin
        // next_due + reached * period equals now - remainder + period.
        rem_nxt   = au_rsp.res;
        state_nxt = ST_FWD;
      end
      ST_FWD: begin
        next_due_nxt = au_rsp.res;
        play_nxt     = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (play_r) begin
          queued_nxt  = QW'(qx - played);
          starved_nxt = DEPTH_W'(starved);
          drn_nxt     = sat_add(drn_r, 32'(played));
          und_nxt     = sat_add(und_r, 32'(starved));
          if (resync_r) begin
            rsy_nxt = sat_add(rsy_r, 32'd1);
          end
          play_nxt = 1'b0;
        end else if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      running_r    <= 1'b0;
      last_stamp_r <= '0;
      next_due_r   <= '0;
      queued_r     <= '0;
      play_r       <= 1'b0;
      acc_r        <= '0;
      ref_r        <= '0;
      drn_r        <= '0;
      und_r        <= '0;
      rsy_r        <= '0;
      skw_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      running_r    <= running_nxt;
      last_stamp_r <= last_stamp_nxt;
      next_due_r   <= next_due_nxt;
      queued_r     <= queued_nxt;
      play_r       <= play_nxt;
      acc_r        <= acc_nxt;
      ref_r        <= ref_nxt;
      drn_r        <= drn_nxt;
      und_r        <= und_nxt;
      rsy_r        <= rsy_nxt;
      skw_r        <= skw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      offer_r <= start_offer;
      now_r   <= start_now;
    end
    rem_r     <= rem_nxt;
    reached_r <= reached_nxt;
    resync_r  <= resync_nxt;
    status_r  <= status_nxt;
    starved_r <= starved_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE) && !play_r;

  always_comb begin
    res.status         = (offer_r == REQ_OFFER) ? status_r : STATUS_OK;
    res.starved_frames = starved_r;
    res.ready_res      = paced && (queued_r < cap);
    res.queued_count   = DEPTH_W'(queued_r);
    res.accepted_count = acc_r;
    res.refused_count  = ref_r;
    res.drained_count  = drn_r;
    res.underrun_count = und_r;
    res.resync_count   = rsy_r;
    res.skew_count     = skw_r;
  end

`ifndef SYNTHESIS
  a_reached_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> reached_r <= RW'(MAX_DRAIN + 1))
    else $error("drain count ran past its bound");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(queued_r) <= 32'(CAP_MAX))
    else $error("queue fill above largest capacity");

  a_unpaced_offer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OFFER && !paced) |=> $stable(queued_r))
    else $error("unpaced offer changed the queue");

  a_drain_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && play_r) |=> queued_r <= $past(queued_r))
    else $error("drain grew the queue");
`endif

endmodule

[bench/paced_frame_sink_tb.sv]
// Self-checking bench for the paced frame sink.
//
// Every beat that the sink accepts is run through a local model of the pacing
// schedule, and the answer that the sink owes is queued. Each result beat that
// leaves the sink is compared, field by field, with the oldest owed answer.
//
// The run has two parts. A short table of directed beats comes first. It
// covers the unpaced mode, anchoring of the schedule, a full queue,
// backward stamps, draining, underruns, a resync and a depth lowered below
// the fill. It also covers timestamps that wrap past the top of the 64-bit
// range. A few rows carry an answer typed in by hand; all other rows use the
// model. After that come fourteen phases of random beats, each under its own
// register setting.
//
// Beats are driven at the falling edge of the clock, and both channels are
// sampled at the rising edge. The sender and the receiver idle at random. The
// first third of the phases favors receiver stalls, the second third favors
// sender gaps, and the last third runs at full rate.
module paced_frame_sink_tb;
  import pfs_pkg::*;

  localparam int          PHASES      = 14;
  localparam int          PHASE_BEATS = 100;
  localparam int          END_WAIT    = 100;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // A row of the directed table: a beat, or a register write between beats.
  typedef struct {
    row_kind_t              kind;
    logic                   req;
    logic [STAMP_W-1:0]     now;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    bit                     typed;
    result_t                want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pfs_in_if  in_bus ();
  pfs_out_if out_bus ();

  paced_frame_sink u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the two registers and of the pacing state.
  logic [PERIOD_W-1:0] period_sh;
  logic [DEPTH_W-1:0]  depth_sh;
  logic                sched_on;
  logic [STAMP_W-1:0]  last_stamp_sh;
  logic [STAMP_W-1:0]  due_at;
  int unsigned         frames_held;
  logic [CNT_W-1:0]    n_accepted;
  logic [CNT_W-1:0]    n_refused;
  logic [CNT_W-1:0]    n_drained;
  logic [CNT_W-1:0]    n_underrun;
  logic [CNT_W-1:0]    n_resync;
  logic [CNT_W-1:0]    n_skew;

  // Answers the sink still owes, oldest first.
  result_t answers_owed[$];
  plan_row_t plan[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned bad_fields;
  int unsigned results_checked;
  int unsigned cycles;
  int unsigned beats_sent;
  int unsigned advances_sent;
  int unsigned settings_used;

  function automatic logic [CNT_W-1:0] clamp_add(logic [CNT_W-1:0] a, int unsigned b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W+1)'(b);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic int unsigned queue_cap();
    if (depth_sh == '0) return DEFAULT_DEPTH_DEF;
    if (int'(depth_sh) > MAX_DEPTH_DEF) return MAX_DEPTH_DEF;
    return 32'(depth_sh);
  endfunction

  // Works out the answer to one accepted beat and moves the shadow state on.
  function automatic result_t paced_answer(logic req, logic [STAMP_W-1:0] now);
    result_t     r;
    logic [63:0] per;
    logic [63:0] reached;
    int unsigned due;
    int unsigned played;
    int unsigned starved;
    logic        refused;
    r = '0;
    starved = 0;
    refused = 1'b0;
    per = 64'(period_sh);
    if (req == REQ_ADVANCE) begin
      if (period_sh == '0) begin
        // Unpaced: a stamp changes nothing at all.
      end else if (sched_on && now < last_stamp_sh) begin
        n_skew = clamp_add(n_skew, 1);
      end else begin
        last_stamp_sh = now;
        if (!sched_on) begin
          // The first stamp anchors the schedule one period ahead.
          sched_on = 1'b1;
          due_at = now + per;
        end else if (now >= due_at) begin
          reached = (now - due_at) / per + 64'd1;
          due = (reached > 64'(MAX_DRAIN_DEF)) ? MAX_DRAIN_DEF : int'(reached);
          played = (due < frames_held) ? due : frames_held;
          starved = due - played;
          frames_held -= played;
          n_drained = clamp_add(n_drained, played);
          n_underrun = clamp_add(n_underrun, starved);
          if (reached > 64'(MAX_DRAIN_DEF)) begin
            // Too far behind: drop the backlog and re-anchor on this stamp.
            due_at = now + per;
            n_resync = clamp_add(n_resync, 1);
          end else begin
            due_at = due_at + reached * per;
          end
        end
      end
    end else begin
      if (period_sh == '0) begin
        n_accepted = clamp_add(n_accepted, 1);
      end else if (frames_held >= queue_cap()) begin
        refused = 1'b1;
        n_refused = clamp_add(n_refused, 1);
      end else begin
        frames_held++;
        n_accepted = clamp_add(n_accepted, 1);
      end
    end
    r.status         = refused ? STATUS_REFUSED : STATUS_OK;
    r.starved_frames = starved[DEPTH_W-1:0];
    r.ready_res      = (period_sh != '0) && (frames_held < queue_cap());
    r.queued_count   = frames_held[DEPTH_W-1:0];
    r.accepted_count = n_accepted;
    r.refused_count  = n_refused;
    r.drained_count  = n_drained;
    r.underrun_count = n_underrun;
    r.resync_count   = n_resync;
    r.skew_count     = n_skew;
    return r;
  endfunction

  function automatic result_t hand_answer(logic st, int unsigned starved, logic rdy,
                                          int unsigned held, int unsigned acc,
                                          int unsigned refd);
    result_t r;
    r = '0;
    r.status         = st;
    r.starved_frames = starved[DEPTH_W-1:0];
    r.ready_res      = rdy;
    r.queued_count   = held[DEPTH_W-1:0];
    r.accepted_count = acc;
    r.refused_count  = refd;
    return r;
  endfunction

  task automatic plan_beat(logic req, logic [STAMP_W-1:0] now);
    plan_row_t row;
    row = '{kind: ROW_BEAT, req: req, now: now, idx: '0, data: '0, typed: 1'b0,
            want: '0};
    plan.push_back(row);
  endtask

  task automatic plan_typed(logic req, logic [STAMP_W-1:0] now, result_t want);
    plan_row_t row;
    row = '{kind: ROW_BEAT, req: req, now: now, idx: '0, data: '0, typed: 1'b1,
            want: want};
    plan.push_back(row);
  endtask

  task automatic plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{kind: ROW_CFG, req: REQ_ADVANCE, now: '0, idx: idx, data: data, typed: 1'b0,
            want: '0};
    plan.push_back(row);
  endtask

  // Offers one beat, holds it until the sink takes it, and then records what
  // the sink owes for it. The task is entered and left at a falling edge, with
  // valid still high, so that back-to-back beats need no gap.
  task automatic send_beat(logic req, logic [STAMP_W-1:0] now, bit typed, result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid    = 1'b1;
    in_bus.req_type = req;
    in_bus.now_us   = now;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    predicted = paced_answer(req, now);
    answers_owed.push_back(typed ? want : predicted);
    beats_sent++;
    if (req == REQ_ADVANCE) advances_sent++;
    @(negedge clk);
  endtask

  // Drops valid and holds off until every owed answer has come back.
  task automatic wait_drained();
    in_bus.valid = 1'b0;
    @(negedge clk);
    while (answers_owed.size() != 0) @(negedge clk);
  endtask

  // One register write, only ever issued while the sink is idle.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_PERIOD) period_sh = data[PERIOD_W-1:0];
    else if (idx == REG_DEPTH) depth_sh = data[DEPTH_W-1:0];
  endtask

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (want !== got) begin
      bad_fields++;
      if (bad_fields <= 10)
        $display("result %0d: %s expected 0x%0h, got 0x%0h",
                 results_checked, name, want, got);
    end
  endtask

  // The receiver decides at each falling edge whether it stalls next cycle.
  always @(negedge clk) begin
    out_bus.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Every result beat taken from the sink is matched against the oldest
  // owed answer.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.status         = out_bus.status;
      got.starved_frames = out_bus.starved_frames;
      got.ready_res      = out_bus.ready_res;
      got.queued_count   = out_bus.queued_count;
      got.accepted_count = out_bus.accepted_count;
      got.refused_count  = out_bus.refused_count;
      got.drained_count  = out_bus.drained_count;
      got.underrun_count = out_bus.underrun_count;
      got.resync_count   = out_bus.resync_count;
      got.skew_count     = out_bus.skew_count;
      if (answers_owed.size() == 0) begin
        bad_fields++;
        if (bad_fields <= 10)
          $display("result beat with no beat waiting for it: queued_count 0x%0h",
                   got.queued_count);
      end else begin
        want = answers_owed.pop_front();
        check_field("status", CNT_W'(want.status), CNT_W'(got.status));
        check_field("starved_frames", CNT_W'(want.starved_frames),
                    CNT_W'(got.starved_frames));
        check_field("ready_res", CNT_W'(want.ready_res), CNT_W'(got.ready_res));
        check_field("queued_count", CNT_W'(want.queued_count),
                    CNT_W'(got.queued_count));
        check_field("accepted_count", want.accepted_count, got.accepted_count);
        check_field("refused_count", want.refused_count, got.refused_count);
        check_field("drained_count", want.drained_count, got.drained_count);
        check_field("underrun_count", want.underrun_count, got.underrun_count);
        check_field("resync_count", want.resync_count, got.resync_count);
        check_field("skew_count", want.skew_count, got.skew_count);
      end
      results_checked++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d answers owed", cycles,
               answers_owed.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [STAMP_W-1:0]    cur_now;
    logic [STAMP_W-1:0]    stamp;
    logic [63:0]           per64;
    int unsigned           per32;
    int unsigned           pick;
    int unsigned           dist_pick;
    int unsigned           back;
    logic                  req;
    logic [PERIOD_W-1:0]   new_period;
    logic [DEPTH_W-1:0]    new_depth;

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PERIOD;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_ADVANCE;
    in_bus.now_us = '0;
    out_bus.ready = 1'b0;
    period_sh = '0;
    depth_sh = '0;
    sched_on = 1'b0;
    last_stamp_sh = '0;
    due_at = '0;
    frames_held = 0;
    n_accepted = '0;
    n_refused = '0;
    n_drained = '0;
    n_underrun = '0;
    n_resync = '0;
    n_skew = '0;
    bad_fields = 0;
    results_checked = 0;
    cycles = 0;
    beats_sent = 0;
    advances_sent = 0;
    settings_used = 1;
    send_idle_pct = 21;
    recv_idle_pct = 69;
    cur_now = '0;

    // Directed table. Right after reset the sink is unpaced, so the first
    // answers can be written down directly.
    plan_typed(REQ_ADVANCE, 64'd0, hand_answer(STATUS_OK, 0, 1'b0, 0, 0, 0));
    plan_typed(REQ_OFFER, 64'd0, hand_answer(STATUS_OK, 0, 1'b0, 0, 1, 0));
    plan_typed(REQ_ADVANCE, '1, hand_answer(STATUS_OK, 0, 1'b0, 0, 1, 0));
    // Period 10; depth 2, written with junk above the seven depth bits.
    plan_cfg(REG_PERIOD, 20'd10);
    plan_cfg(REG_DEPTH, 20'hF82);
    plan_beat(REQ_ADVANCE, 64'd100);         // anchors, first frame due at 110
    plan_beat(REQ_OFFER, 64'd0);
    plan_beat(REQ_OFFER, 64'd0);             // queue now full
    plan_typed(REQ_OFFER, 64'd0, hand_answer(STATUS_REFUSED, 0, 1'b0, 2, 3, 1));
    plan_beat(REQ_ADVANCE, 64'd50);          // older than the last stamp: skew
    plan_beat(REQ_ADVANCE, 64'd105);         // not yet due
    plan_beat(REQ_ADVANCE, 64'd125);         // two frames due and played
    plan_beat(REQ_ADVANCE, 64'd155);         // three due, queue empty: underruns
    plan_beat(REQ_ADVANCE, 64'd1000);        // far behind: resync
    plan_cfg(REG_DEPTH, 20'd127);            // capacity clamps at the maximum
    plan_beat(REQ_OFFER, 64'd0);
    plan_beat(REQ_OFFER, 64'd0);
    plan_cfg(REG_DEPTH, 20'd1);              // depth now below the fill
    plan_beat(REQ_OFFER, 64'd0);
    plan_beat(REQ_ADVANCE, 64'd1005);
    plan_cfg(REG_PERIOD, 20'hFFFFF);         // widest period, above one second
    plan_beat(REQ_ADVANCE, 64'hFFFF_FFFF_FFFF_FFF0);  // next due wraps past zero
    plan_beat(REQ_ADVANCE, '1);
    plan_cfg(REG_PERIOD, 20'd1000000);
    plan_beat(REQ_ADVANCE, 64'd0);
    plan_beat(REQ_OFFER, 64'd0);
    plan_cfg(REG_PERIOD, 20'd0);             // back to pass-through with a fill
    plan_beat(REQ_OFFER, 64'd0);
    plan_beat(REQ_ADVANCE, 64'd7);

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(plan[i].idx, plan[i].data);
        settings_used++;
      end else begin
        send_beat(plan[i].req, plan[i].now, plan[i].typed, plan[i].want);
      end
    end

    // Random phases. The first few phases pin the register extremes, and the
    // rest draw them at random. Small periods dominate so that stamps land
    // near the schedule and the queue keeps filling and draining.
    cur_now = last_stamp_sh;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < PHASES / 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 69;
      end else if (phase < 2 * PHASES / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      case (phase)
        0: begin new_period = 20'd1; new_depth = 7'd1; end
        1: begin new_period = 20'hFFFFF; new_depth = 7'd127; end
        2: begin new_period = 20'd0; new_depth = 7'd64; end
        3: begin new_period = 20'd1000000; new_depth = 7'd0; end
        default: begin
          pick = $urandom_range(99);
          if (pick < 10) new_period = '0;
          else if (pick < 20) new_period = PERIOD_W'($urandom_range(20'hFFFFF, 20'd1000000));
          else if (pick < 30) new_period = PERIOD_W'($urandom_range(100000, 1));
          else new_period = PERIOD_W'($urandom_range(40, 1));
          pick = $urandom_range(99);
          if (pick < 15) new_depth = '0;
          else if (pick < 25) new_depth = DEPTH_W'($urandom_range(127, 65));
          else if (pick < 35) new_depth = 7'd64;
          else new_depth = DEPTH_W'($urandom_range(12, 1));
        end
      endcase
      cfg_write(REG_PERIOD, new_period);
      cfg_write(REG_DEPTH, {13'($urandom_range(8191, 0)), new_depth});
      settings_used++;

      for (int k = 0; k < PHASE_BEATS; k++) begin
        // Now and then the sender holds off until the sink has answered all.
        if ($urandom_range(99) < 2) wait_drained();
        per32 = (period_sh == '0) ? 1 : int'(period_sh);
        per64 = 64'(per32);
        if ($urandom_range(99) < 45) begin
          req = REQ_OFFER;
          stamp = {$urandom(), $urandom()};
        end else begin
          req = REQ_ADVANCE;
          dist_pick = $urandom_range(99);
          if (dist_pick < 55) begin
            cur_now = cur_now + 64'($urandom_range(2 * per32 + 1, 0));
            stamp = cur_now;
          end else if (dist_pick < 70) begin
            cur_now = cur_now + per64 * 64'($urandom_range(4, 0))
                      + 64'($urandom_range(3, 0));
            stamp = cur_now;
          end else if (dist_pick < 80) begin
            // A stamp behind the last one; the running time is left alone.
            back = $urandom_range(3 * per32, 1);
            stamp = (cur_now >= 64'(back)) ? cur_now - 64'(back) : cur_now;
          end else if (dist_pick < 90) begin
            // Jump well past the drain cap to force a resync.
            cur_now = cur_now + per64 * 64'($urandom_range(300, 65))
                      + 64'($urandom_range(per32, 0));
            stamp = cur_now;
          end else if (dist_pick < 95) begin
            cur_now = {$urandom(), $urandom()};
            stamp = cur_now;
          end else begin
            stamp = cur_now;
          end
        end
        send_beat(req, stamp, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (END_WAIT) @(negedge clk);

    $display("Run covered %0d beats (%0d advances) under %0d register settings;",
             beats_sent, advances_sent, settings_used);
    $display("%0d results checked, %0d resyncs and %0d skewed stamps along the way.",
             results_checked, n_resync, n_skew);
    if (bad_fields == 0 && answers_owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/pfs_pkg.sv
hdl/pfs_if.sv
hdl/pfs_addsub.sv
hdl/pfs_seq.sv
hdl/paced_frame_sink.sv
bench/paced_frame_sink_tb.sv
